// ===== hdl/kinematic_bicycle_step_top_assert.svh =====
// Assertion macros for the kinematic bicycle step block
`ifndef KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH
`define KINEMATIC_BICYCLE_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define KBS_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("kbs assertion failed");

// next-cycle implication
`define KBS_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("kbs assertion failed");

`endif

// ===== hdl/kbs_pkg.sv =====
// Package: constants, register indexes and CORDIC table for the bicycle step block
package kbs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CNT_W     = 5;

    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [19:0] PI_F        = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_F    = 20'sd411774;
    localparam logic [17:0]        PI_F_U      = 18'd205887;

    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_INV_WB    = 2'd1;
    localparam logic [1:0] CFG_SPEED_MIN = 2'd2;
    localparam logic [1:0] CFG_SPEED_MAX = 2'd3;

    localparam logic [15:0] TIME_STEP_RST = 16'd3277;
    localparam logic [21:0] INV_WB_RST    = 22'd436907;
    localparam logic [17:0] SPEED_MIN_RST = 18'd6554;
    localparam logic [17:0] SPEED_MAX_RST = 18'd98304;
    localparam logic [17:0] SPEED_RST     = 18'd32768;

    function automatic logic signed [33:0] atan_q30(input logic [CNT_W-1:0] i);
        logic signed [33:0] r;
        unique case (i)
            5'd0:    r = 34'sh03243F6A8;
            5'd1:    r = 34'sh01DAC6705;
            5'd2:    r = 34'sh00FADBAFC;
            5'd3:    r = 34'sh007F56EA6;
            5'd4:    r = 34'sh003FEAB76;
            5'd5:    r = 34'sh001FFD55B;
            5'd6:    r = 34'sh000FFFAAA;
            5'd7:    r = 34'sh0007FFF55;
            5'd8:    r = 34'sh0003FFFEA;
            5'd9:    r = 34'sh0001FFFFD;
            5'd10:   r = 34'sh0000FFFFF;
            5'd11:   r = 34'sh00007FFFF;
            5'd12:   r = 34'sh00003FFFF;
            5'd13:   r = 34'sh00001FFFF;
            5'd14:   r = 34'sh00000FFFF;
            5'd15:   r = 34'sh000007FFF;
            5'd16:   r = 34'sh000003FFF;
            5'd17:   r = 34'sh000001FFF;
            5'd18:   r = 34'sh000000FFF;
            5'd19:   r = 34'sh0000007FF;
            5'd20:   r = 34'sh0000003FF;
            5'd21:   r = 34'sh0000001FF;
            5'd22:   r = 34'sh0000000FF;
            5'd23:   r = 34'sh00000007F;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/kinematic_bicycle_step_top.sv =====
// Top level: kinematic bicycle step with a shared CORDIC / multiplier / divider sequencer
//
//  channel  | dir | payload
//  s_axis   | in  | throttle_accel, steer_angle
//  m_axis   | out | pos_x, pos_y, heading, speed
//  cfg      | in  | time_step, inverse_wheelbase, speed_min, speed_max
//
// Each step runs two CORDIC passes on the shared rotate unit, seven products on one 32x24
// multiplier, and 18 restoring divide steps when the quotient is not trivial.
// s_axis_tready is high only while idle. A result waits in the output
// register; the next step is accepted meanwhile and finishes once it is taken.
// rst_n clears state and restores register defaults.
module kinematic_bicycle_step_top #(
    parameter int CORDIC_ITERS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // throttle_accel[18:0], steer_angle[36:19]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // pos_x[31:0], pos_y[63:32], heading[82:64],
                                         // speed[100:83]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [21:0]  cfg_data
);

    localparam int FB = kbs_pkg::FRAC_BITS;
    localparam int CW = kbs_pkg::CNT_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_VMUL   = 4'd1;
    localparam logic [3:0] ST_VCLAMP = 4'd2;
    localparam logic [3:0] ST_CORD   = 4'd3;
    localparam logic [3:0] ST_TRAVEL = 4'd4;
    localparam logic [3:0] ST_XMUL   = 4'd5;
    localparam logic [3:0] ST_XUPD   = 4'd6;
    localparam logic [3:0] ST_YUPD   = 4'd7;
    localparam logic [3:0] ST_TURN1  = 4'd8;
    localparam logic [3:0] ST_TURN2  = 4'd9;
    localparam logic [3:0] ST_DIVCHK = 4'd10;
    localparam logic [3:0] ST_DIV    = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    logic [3:0]  state_reg;
    logic [15:0] dt_reg;
    logic [21:0] iwb_reg;
    logic [17:0] vmin_reg, vmax_reg;
    logic [31:0] x_reg, y_reg;
    logic [18:0] heading_reg;
    logic [17:0] speed_reg;
    logic [18:0] thr_reg;
    logic [17:0] steer_reg;
    logic [17:0] v_reg;
    logic [55:0] prod_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic        neg_reg, pass_reg;
    logic [CW-1:0] cnt_reg;
    logic signed [33:0] hc_reg, hs_reg, sc_reg, ss_reg;
    logic [17:0] travel_reg;
    logic [55:0] rem_reg;
    logic [49:0] dsh_reg;
    logic [17:0] q_reg;
    logic        out_valid_reg;
    logic [103:0] out_data_reg;

    logic [31:0] mul_a;
    logic [23:0] mul_b;

    function automatic logic [31:0] mag32(input logic signed [33:0] v);
        logic signed [33:0] a;
        a = v[33] ? -v : v;
        return a[31:0];
    endfunction

    logic [18:0] thr_mag;
    logic [31:0] hc_mag, hs_mag, sc_mag, ss_mag;
    assign thr_mag = thr_reg[18] ? (~thr_reg + 19'd1) : thr_reg;
    assign hc_mag  = mag32(hc_reg);
    assign hs_mag  = mag32(hs_reg);
    assign sc_mag  = mag32(sc_reg);
    assign ss_mag  = mag32(ss_reg);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 24'd0;
        unique case (state_reg)
            ST_VMUL:
            begin
                mul_a = {13'd0, thr_mag};
                mul_b = {8'd0, dt_reg};
            end
            ST_TRAVEL:
            begin
                mul_a = {14'd0, v_reg};
                mul_b = {8'd0, dt_reg};
            end
            ST_XMUL:
            begin
                mul_a = hc_mag;
                mul_b = {6'd0, prod_reg[FB+17:FB]};
            end
            ST_XUPD:
            begin
                mul_a = hs_mag;
                mul_b = {6'd0, travel_reg};
            end
            ST_YUPD:
            begin
                mul_a = {14'd0, v_reg};
                mul_b = {2'd0, iwb_reg};
            end
            ST_TURN1:
            begin
                mul_a = {8'd0, prod_reg[FB+23:FB]};
                mul_b = {8'd0, dt_reg};
            end
            ST_TURN2:
            begin
                mul_a = ss_mag;
                mul_b = prod_reg[FB+23:FB];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 24'd0;
            end
        endcase
    end

    // speed update and clamp
    logic signed [20:0] vsum, vlim;
    logic [17:0]        vclamp;
    always_comb
    begin
        if (thr_reg[18])
            vsum = $signed({3'd0, speed_reg}) - $signed({3'd0, prod_reg[FB+17:FB]});
        else
            vsum = $signed({3'd0, speed_reg}) + $signed({3'd0, prod_reg[FB+17:FB]});
        if (vsum > $signed({3'd0, vmax_reg}))
            vlim = $signed({3'd0, vmax_reg});
        else
            vlim = vsum;
        if (vlim < $signed({3'd0, vmin_reg}))
            vclamp = vmin_reg;
        else
            vclamp = vlim[17:0];
    end

    // CORDIC start: fold into [-pi/2, pi/2]
    logic [18:0]        cord_ang;
    logic signed [33:0] z0, z0_fold;
    logic               z0_neg;
    assign cord_ang = (state_reg == ST_VCLAMP) ? heading_reg : {steer_reg[17], steer_reg};
    always_comb
    begin
        z0 = $signed({cord_ang[18], cord_ang, 14'd0});
        z0_fold = z0;
        z0_neg = 1'b0;
        if (z0 > kbs_pkg::HALF_PI_Q30)
        begin
            z0_fold = z0 - kbs_pkg::PI_Q30;
            z0_neg = 1'b1;
        end
        else if (z0 < -kbs_pkg::HALF_PI_Q30)
        begin
            z0_fold = z0 + kbs_pkg::PI_Q30;
            z0_neg = 1'b1;
        end
    end

    // shared rotate unit
    logic signed [33:0] cx_n, cy_n, cz_n, atan_v;
    assign atan_v = kbs_pkg::atan_q30(cnt_reg);
    always_comb
    begin
        if (!cz_reg[33])
        begin
            cx_n = cx_reg - (cy_reg >>> cnt_reg);
            cy_n = cy_reg + (cx_reg >>> cnt_reg);
            cz_n = cz_reg - atan_v;
        end
        else
        begin
            cx_n = cx_reg + (cy_reg >>> cnt_reg);
            cy_n = cy_reg - (cx_reg >>> cnt_reg);
            cz_n = cz_reg + atan_v;
        end
    end

    // position update with saturation
    function automatic logic [31:0] pos_add(input logic [31:0] p, input logic neg,
                                            input logic [25:0] d);
        logic signed [33:0] s;
        if (neg)
            s = $signed({{2{p[31]}}, p}) - $signed({8'd0, d});
        else
            s = $signed({{2{p[31]}}, p}) + $signed({8'd0, d});
        if (s > 34'sd2147483647)
            s = 34'sd2147483647;
        else if (s < -34'sd2147483648)
            s = -34'sd2147483648;
        return s[31:0];
    endfunction

    // divide check and step
    logic [55:0] den_lim;
    logic        rem_ge;
    assign den_lim = {6'd0, sc_mag, 18'd0};
    assign rem_ge  = rem_reg >= {6'd0, dsh_reg};

    // heading finish
    logic [17:0]        q_sat;
    logic signed [19:0] h_sum, h_wrap;
    logic               inc_neg;
    assign q_sat   = (q_reg > kbs_pkg::PI_F_U) ? kbs_pkg::PI_F_U : q_reg;
    assign inc_neg = ss_reg[33] != sc_reg[33];
    always_comb
    begin
        if (inc_neg)
            h_sum = $signed({heading_reg[18], heading_reg}) - $signed({2'd0, q_sat});
        else
            h_sum = $signed({heading_reg[18], heading_reg}) + $signed({2'd0, q_sat});
        if (h_sum > kbs_pkg::PI_F)
            h_wrap = h_sum - kbs_pkg::TWO_PI_F;
        else if (h_sum < -kbs_pkg::PI_F)
            h_wrap = h_sum + kbs_pkg::TWO_PI_F;
        else
            h_wrap = h_sum;
    end

    logic out_free;
    logic out_load;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_DONE) && out_free;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 56'(mul_a * mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dt_reg        <= kbs_pkg::TIME_STEP_RST;
            iwb_reg       <= kbs_pkg::INV_WB_RST;
            vmin_reg      <= kbs_pkg::SPEED_MIN_RST;
            vmax_reg      <= kbs_pkg::SPEED_MAX_RST;
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            heading_reg   <= 19'd0;
            speed_reg     <= kbs_pkg::SPEED_RST;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    kbs_pkg::CFG_TIME_STEP: dt_reg   <= cfg_data[15:0];
                    kbs_pkg::CFG_INV_WB:    iwb_reg  <= cfg_data;
                    kbs_pkg::CFG_SPEED_MIN: vmin_reg <= cfg_data[17:0];
                    kbs_pkg::CFG_SPEED_MAX: vmax_reg <= cfg_data[17:0];
                    default:                dt_reg   <= dt_reg;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        thr_reg   <= s_axis_tdata[18:0];
                        steer_reg <= s_axis_tdata[36:19];
                        state_reg <= ST_VMUL;
                    end
                end
                ST_VMUL:
                    state_reg <= ST_VCLAMP;
                ST_VCLAMP:
                begin
                    v_reg     <= vclamp;
                    cx_reg    <= kbs_pkg::GAIN_Q30;
                    cy_reg    <= 34'sd0;
                    cz_reg    <= z0_fold;
                    neg_reg   <= z0_neg;
                    cnt_reg   <= '0;
                    pass_reg  <= 1'b0;
                    state_reg <= ST_CORD;
                end
                ST_CORD:
                begin
                    if (cnt_reg == CW'(CORDIC_ITERS - 1))
                    begin
                        cnt_reg <= '0;
                        if (!pass_reg)
                        begin
                            hc_reg   <= neg_reg ? -cx_n : cx_n;
                            hs_reg   <= neg_reg ? -cy_n : cy_n;
                            cx_reg   <= kbs_pkg::GAIN_Q30;
                            cy_reg   <= 34'sd0;
                            cz_reg   <= z0_fold;
                            neg_reg  <= z0_neg;
                            pass_reg <= 1'b1;
                        end
                        else
                        begin
                            sc_reg    <= neg_reg ? -cx_n : cx_n;
                            ss_reg    <= neg_reg ? -cy_n : cy_n;
                            state_reg <= ST_TRAVEL;
                        end
                    end
                    else
                    begin
                        cx_reg  <= cx_n;
                        cy_reg  <= cy_n;
                        cz_reg  <= cz_n;
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                ST_TRAVEL:
                    state_reg <= ST_XMUL;
                ST_XMUL:
                begin
                    travel_reg <= prod_reg[FB+17:FB];
                    state_reg  <= ST_XUPD;
                end
                ST_XUPD:
                begin
                    x_reg     <= pos_add(x_reg, hc_reg[33], prod_reg[55:30]);
                    state_reg <= ST_YUPD;
                end
                ST_YUPD:
                begin
                    y_reg     <= pos_add(y_reg, hs_reg[33], prod_reg[55:30]);
                    state_reg <= ST_TURN1;
                end
                ST_TURN1:
                    state_reg <= ST_TURN2;
                ST_TURN2:
                    state_reg <= ST_DIVCHK;
                ST_DIVCHK:
                begin
                    priority if (prod_reg == 56'd0)
                    begin
                        q_reg     <= 18'd0;
                        state_reg <= ST_DONE;
                    end
                    else if (prod_reg >= den_lim)
                    begin
                        q_reg     <= kbs_pkg::PI_F_U;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rem_reg   <= prod_reg;
                        dsh_reg   <= {1'b0, sc_mag, 17'd0};
                        q_reg     <= 18'd0;
                        cnt_reg   <= CW'(17);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (rem_ge)
                        rem_reg <= rem_reg - {6'd0, dsh_reg};
                    q_reg   <= {q_reg[16:0], rem_ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (cnt_reg == '0)
                        state_reg <= ST_DONE;
                    else
                        cnt_reg <= cnt_reg - CW'(1);
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        heading_reg   <= h_wrap[18:0];
                        speed_reg     <= v_reg;
                        out_data_reg  <= {3'd0, v_reg, h_wrap[18:0], y_reg, x_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/kbs_checker.sv =====
// Port checker for the bicycle step block, bound to the top level
`include "kinematic_bicycle_step_top_assert.svh"

module kbs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [103:0] m_axis_tdata
);

    logic signed [18:0] hd;
    assign hd = m_axis_tdata[82:64];

    `KBS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `KBS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `KBS_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `KBS_ASSERT_NOW(a_heading_range, m_axis_tvalid,
        ($signed({hd[18], hd}) <= kbs_pkg::PI_F) && ($signed({hd[18], hd}) >= -kbs_pkg::PI_F))

endmodule

bind kinematic_bicycle_step_top kbs_checker u_kbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb.sv =====
// Testbench for the kinematic bicycle step block: predictor, stimulus and result checks
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [18:0] heading;
        logic [17:0]        speed;
    } vehicle_state_t;

    localparam int STEP_CYCLES = 80;
    localparam int STALL_LIMIT = 5000;
    localparam int ROT_ITERS   = 16;

    localparam longint ARCTAN_Q30 [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [21:0]  cfg_data;

    kinematic_bicycle_step_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    // model state and register copies
    logic signed [31:0] veh_x;
    logic signed [31:0] veh_y;
    logic signed [18:0] veh_head;
    logic [17:0]        veh_speed;
    logic [15:0]        dt_reg;
    logic [21:0]        inv_wb_reg;
    logic [17:0]        vmin_reg;
    logic [17:0]        vmax_reg;

    vehicle_state_t pending_states[$];
    int errors;
    int steps_sent;
    int states_checked;
    int cfg_writes;
    int idle_cycles;
    int stall_left;
    bit calm;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint mul_trunc(input longint a, input longint unsigned b,
                                         input int sh);
        longint unsigned m;
        m = ((a < 0 ? -a : a) * b) >> sh;
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic void sin_cos(input longint ang_f, output longint c, output longint s);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit flip;
        z = ang_f * 64'sd16384;
        x = longint'(kbs_pkg::GAIN_Q30);
        y = 0;
        flip = 1'b0;
        if (z > longint'(kbs_pkg::HALF_PI_Q30))
        begin
            z -= longint'(kbs_pkg::PI_Q30);
            flip = 1'b1;
        end
        else if (z < -longint'(kbs_pkg::HALF_PI_Q30))
        begin
            z += longint'(kbs_pkg::PI_Q30);
            flip = 1'b1;
        end
        for (int i = 0; i < ROT_ITERS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ARCTAN_Q30[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ARCTAN_Q30[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void advance_vehicle(input logic signed [18:0] thr,
                                            input logic signed [17:0] steer);
        longint v;
        longint hc;
        longint hs;
        longint sc;
        longint ss;
        longint h;
        longint inc;
        longint pi_f;
        longint unsigned travel;
        longint unsigned turn;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        vehicle_state_t e;
        pi_f = longint'(kbs_pkg::PI_F);
        v = longint'(veh_speed) + mul_trunc(longint'(thr), dt_reg, kbs_pkg::FRAC_BITS);
        if (v > longint'(vmax_reg))
            v = longint'(vmax_reg);
        if (v < longint'(vmin_reg))
            v = longint'(vmin_reg);
        sin_cos(longint'(veh_head), hc, hs);
        travel = (longint'(v) * dt_reg) >> kbs_pkg::FRAC_BITS;
        veh_x = clip32(longint'(veh_x) + mul_trunc(hc, travel, 30));
        veh_y = clip32(longint'(veh_y) + mul_trunc(hs, travel, 30));
        turn = (((longint'(v) * inv_wb_reg) >> kbs_pkg::FRAC_BITS) * dt_reg)
               >> kbs_pkg::FRAC_BITS;
        if (turn > 64'hFFFFFFFF)
            turn = 64'hFFFFFFFF;
        sin_cos(longint'(steer), sc, ss);
        num = turn * (ss < 0 ? -ss : ss);
        den = sc < 0 ? -sc : sc;
        if (num == 0)
            q = 0;
        else if (den == 0)
            q = pi_f;
        else
            q = num / den;
        if (q > pi_f)
            q = pi_f;
        inc = ((ss < 0) != (sc < 0)) ? -longint'(q) : longint'(q);
        h = longint'(veh_head) + inc;
        if (h > pi_f)
            h -= 2 * pi_f;
        else if (h < -pi_f)
            h += 2 * pi_f;
        veh_head  = h[18:0];
        veh_speed = v[17:0];
        e.pos_x   = veh_x;
        e.pos_y   = veh_y;
        e.heading = veh_head;
        e.speed   = veh_speed;
        pending_states.push_back(e);
    endfunction

    // valid stays high between back-to-back transfers
    task automatic send_step(input logic signed [18:0] thr, input logic signed [17:0] steer);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, steer, thr};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_vehicle(thr, steer);
        steps_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_states.size() != 0)
            @(posedge clk);
        repeat (STEP_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [21:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        case (addr)
            kbs_pkg::CFG_TIME_STEP: dt_reg     = value[15:0];
            kbs_pkg::CFG_INV_WB:    inv_wb_reg = value;
            kbs_pkg::CFG_SPEED_MIN: vmin_reg   = value[17:0];
            kbs_pkg::CFG_SPEED_MAX: vmax_reg   = value[17:0];
        endcase
        cfg_writes++;
    endtask

    task automatic load_config(input logic [15:0] dt, input logic [21:0] iwb,
                               input logic [17:0] vmin, input logic [17:0] vmax);
        wait_idle();
        write_reg(kbs_pkg::CFG_TIME_STEP, {6'd0, dt});
        write_reg(kbs_pkg::CFG_INV_WB, iwb);
        write_reg(kbs_pkg::CFG_SPEED_MIN, {4'd0, vmin});
        write_reg(kbs_pkg::CFG_SPEED_MAX, {4'd0, vmax});
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_extremes();
        send_step(19'sd0, 18'sd0);
        send_step(19'sd131072, 18'sd0);
        send_step(-19'sd131072, 18'sd0);
        send_step(19'sd131072, 18'sd65536);
        send_step(19'sd0, -18'sd65536);
        send_step(19'sd1, 18'sd1);
        send_step(-19'sd1, -18'sd1);
        send_step(19'sd65536, 18'sd32768);
    endtask

    task automatic test_heading_wrap();
        // big turn rate saturates the increment at pi; repeated turns wrap heading
        load_config(16'd65535, 22'd4194303, 18'd0, 18'd262143);
        for (int i = 0; i < 6; i++)
            send_step(19'sd131072, 18'sd65536);
        for (int i = 0; i < 6; i++)
            send_step(-19'sd1000, -18'sd40000);
        send_step(-19'sd131072, 18'sd0);
    endtask

    task automatic test_clamp_bounds();
        // swapped bounds pin speed to the minimum
        load_config(16'd3277, 22'd436907, 18'd200000, 18'd1000);
        send_step(19'sd131072, 18'sd100);
        send_step(-19'sd131072, -18'sd100);
        load_config(16'd1, 22'd1, 18'd0, 18'd0);
        send_step(19'sd131072, 18'sd65536);
        send_step(-19'sd131072, -18'sd65536);
    endtask

    task automatic test_random_steps();
        logic [15:0] dt;
        logic [21:0] iwb;
        logic [17:0] lo;
        logic [17:0] hi;
        logic signed [18:0] thr;
        logic signed [17:0] steer;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: load_config(kbs_pkg::TIME_STEP_RST, kbs_pkg::INV_WB_RST,
                               kbs_pkg::SPEED_MIN_RST, kbs_pkg::SPEED_MAX_RST);
                1: load_config(16'd65535, 22'd4194303, 18'd0, 18'd262143);
                default:
                begin
                    dt  = $urandom_range(1, 65535);
                    iwb = $urandom_range(1, 4194303);
                    lo  = $urandom_range(0, 262143);
                    hi  = $urandom_range(0, 262143);
                    if ($urandom_range(0, 3) != 0 && lo > hi)
                        lo = hi >> 2;
                    load_config(dt, iwb, lo, hi);
                end
            endcase
            for (int n = 0; n < 230; n++)
            begin
                if (n % 50 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                begin
                    thr   = $urandom_range(0, 262144) - 131072;
                    steer = $urandom_range(0, 131072) - 65536;
                end
                else
                begin
                    thr   = $urandom_range(0, 40000) - 20000;
                    steer = $urandom_range(0, 30000) - 15000;
                end
                send_step(thr, steer);
            end
            calm = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        logic next_ready;
        if (stall_left > 0)
        begin
            stall_left--;
            next_ready = 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left = pick_gap();
            next_ready = (stall_left == 0);
        end
        else
            next_ready = 1'b1;
        m_axis_tready <= next_ready;
    end

    always @(posedge clk)
    begin
        vehicle_state_t got;
        vehicle_state_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pos_x   = m_axis_tdata[31:0];
            got.pos_y   = m_axis_tdata[63:32];
            got.heading = m_axis_tdata[82:64];
            got.speed   = m_axis_tdata[100:83];
            if (pending_states.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = pending_states.pop_front();
                states_checked++;
                if (got.pos_x !== want.pos_x)
                begin
                    $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x, got.pos_x);
                    errors++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y, got.pos_y);
                    errors++;
                end
                if (got.heading !== want.heading)
                begin
                    $display("%0t: heading expected %0d got %0d", $time, want.heading,
                             got.heading);
                    errors++;
                end
                if (got.speed !== want.speed)
                begin
                    $display("%0t: speed expected %0d got %0d", $time, want.speed, got.speed);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: timeout after %0d cycles without a transfer", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= kbs_pkg::CFG_TIME_STEP;
        cfg_data      <= '0;
        errors = 0;
        steps_sent = 0;
        states_checked = 0;
        cfg_writes = 0;
        idle_cycles = 0;
        stall_left = 0;
        calm = 1'b0;
        veh_x = '0;
        veh_y = '0;
        veh_head = '0;
        veh_speed = kbs_pkg::SPEED_RST;
        dt_reg = kbs_pkg::TIME_STEP_RST;
        inv_wb_reg = kbs_pkg::INV_WB_RST;
        vmin_reg = kbs_pkg::SPEED_MIN_RST;
        vmax_reg = kbs_pkg::SPEED_MAX_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_heading_wrap();
        test_clamp_bounds();
        test_random_steps();
        wait_idle();

        if (pending_states.size() != 0)
        begin
            $display("tb: %0d results never arrived", pending_states.size());
            errors++;
        end
        $display("tb: %0d steps sent, %0d states checked, %0d register writes",
                 steps_sent, states_checked, cfg_writes);
        $display("tb: covered throttle/steer extremes, heading wrap, swapped clamps");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
